[design/forward_moving_average_core_defines.svh]
// Assertion helpers for the checks in forward_moving_average_core.sv.
`ifndef FORWARD_MOVING_AVERAGE_CORE_DEFINES_SVH
`define FORWARD_MOVING_AVERAGE_CORE_DEFINES_SVH

`define FMA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FMA_CHECK(label, prop, msg) \
  `FMA_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

[design/fma_pkg.sv]
`default_nettype none
package fma_pkg;

  localparam int unsigned WLEN_W     = 5;
  localparam int unsigned WLEN_RESET = 5;

  typedef struct packed {
    logic push;
    logic start;
    logic emit;
    logic clear;
  } fma_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic stream_end;
    logic div_done;
    logic out_free;
  } fma_sts_t;

endpackage
`default_nettype wire

[design/fma_if.sv]
`default_nettype none
interface fma_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface fma_out_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] average;
  logic                           last_out;

  modport source (output valid, output average, output last_out, input ready);
  modport sink   (input valid, input average, input last_out, output ready);
endinterface

interface fma_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface
`default_nettype wire

[design/fma_ram.sv]
`default_nettype none
module fma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[design/fma_div.sv]
`default_nettype none
module fma_div #(
  parameter int unsigned DIVIDEND_W = 21,
  parameter int unsigned DIVISOR_W  = 5,
  parameter int unsigned QUOT_W     = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [DIVIDEND_W-1:0] dividend_i,
  input  wire logic        [DIVISOR_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic signed      [QUOT_W-1:0]     quotient_o
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     step_q;
  logic                  neg_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;

  logic [DIVIDEND_W-1:0] mag;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [QUOT_W-1:0]     q_mag;

  // Restoring division on the magnitude, one quotient bit per cycle.
  assign mag   = dividend_i[DIVIDEND_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = !diff[DIVISOR_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIVIDEND_W-1];
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= mag;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign q_mag      = quo_q[QUOT_W-1:0];
  assign quotient_o = neg_q ? (~q_mag + 1'b1) : q_mag;
  assign done_o     = done_q;

endmodule
`default_nettype wire

[design/fma_datapath.sv]
`default_nettype none
module fma_datapath #(
  parameter int unsigned MAX_WINDOW   = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire fma_pkg::fma_cmd_t              cmd_i,
  output fma_pkg::fma_sts_t                   sts_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic                           last_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [fma_pkg::WLEN_W-1:0]     cfg_wdata_i,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0]      out_average_o,
  output logic                                out_last_o
);
  import fma_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W = SAMPLE_WIDTH + CNT_W;
  localparam int unsigned CMP_W = (WLEN_W > CNT_W) ? WLEN_W : CNT_W;

  logic [WLEN_W-1:0]             window_len_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic [CNT_W-1:0]              count_q;
  logic [PTR_W-1:0]              wp_q;
  logic [PTR_W-1:0]              rp_q;
  logic                          last_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_avg_q;
  logic                          out_last_q;

  logic [CMP_W-1:0]               wl_ext;
  logic [CMP_W-1:0]               eff_win;
  logic [CMP_W-1:0]               cnt_ext;
  logic [SAMPLE_WIDTH-1:0]        ram_rdata;
  logic signed [SAMPLE_WIDTH-1:0] oldest;
  logic                           div_done;
  logic signed [SAMPLE_WIDTH-1:0] quotient;
  logic                           out_free;

  assign wl_ext  = CMP_W'(window_len_q);
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    priority if (wl_ext == '0) begin
      eff_win = CMP_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      eff_win = CMP_W'(MAX_WINDOW);
    end else begin
      eff_win = wl_ext;
    end
  end

  assign oldest   = ram_rdata;
  assign out_free = !out_valid_q || out_ready_i;

  fma_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .re_i    (cmd_i.start),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  fma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W),
    .QUOT_W     (SAMPLE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WLEN_W'(WLEN_RESET);
      sum_q        <= '0;
      count_q      <= '0;
      wp_q         <= '0;
      rp_q         <= '0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_len_q <= cfg_wdata_i;
      end
      if (cmd_i.push) begin
        sum_q   <= sum_q + SUM_W'(sample_i);
        count_q <= count_q + 1'b1;
        wp_q    <= (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
        last_q  <= last_i;
      end else if (cmd_i.emit) begin
        sum_q   <= sum_q - SUM_W'(oldest);
        count_q <= count_q - 1'b1;
        rp_q    <= (rp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : rp_q + 1'b1;
      end else if (cmd_i.clear) begin
        sum_q   <= '0;
        count_q <= '0;
        wp_q    <= '0;
        rp_q    <= '0;
        last_q  <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_avg_q  <= quotient;
      out_last_q <= last_q && (count_q == CNT_W'(1));
    end
  end

  assign sts_o.emit_req   = (count_q != '0) && (last_q || (cnt_ext >= eff_win));
  assign sts_o.stream_end = last_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign out_average_o = out_avg_q;
  assign out_last_o    = out_last_q;

endmodule
`default_nettype wire

[design/fma_ctrl.sv]
`default_nettype none
module fma_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fma_pkg::fma_sts_t sts_i,
  output fma_pkg::fma_cmd_t      cmd_o
);
  import fma_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.push = in_valid_i && in_ready_q;
      end
      ST_CHECK: begin
        cmd_o.start = sts_i.emit_req;
        cmd_o.clear = !sts_i.emit_req && sts_i.stream_end;
      end
      ST_DIV: begin
        cmd_o.emit = sts_i.div_done && sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.push) begin
            state_q    <= ST_CHECK;
            in_ready_q <= 1'b0;
          end else begin
            in_ready_q <= 1'b1;
          end
        end
        ST_CHECK: begin
          if (sts_i.emit_req) begin
            state_q <= ST_DIV;
          end else begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        ST_DIV: begin
          if (cmd_o.emit) begin
            state_q <= ST_CHECK;
          end
        end
        default: begin
          state_q    <= ST_IDLE;
          in_ready_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;

endmodule
`default_nettype wire

[design/forward_moving_average_core.sv]
// Channel  Dir  Payload                 Handshake
// in_i     in   sample, last            valid/ready
// out_o    out  average, last_out       valid/ready
// cfg_i    in   window_len              valid/ready, always ready
//
// An input item that completes no window goes from ST_IDLE through ST_CHECK back to ST_IDLE.
// Each average comes from the bit-serial divider working on the SUM_W-bit sum;
// a last item flushes every pending average.
// Reset clears the stream state and sets window_len to 5; no clearing pass.
// A stalled output holds its average; a finished divide holds its quotient
// until the output register drains, and new input is taken once the averages are issued.
`default_nettype none
`include "forward_moving_average_core_defines.svh"
module forward_moving_average_core #(
  parameter int unsigned MAX_WINDOW   = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fma_in_if.sink    in_i,
  fma_out_if.source out_o,
  fma_cfg_if.sink   cfg_i
);
  import fma_pkg::*;

  fma_cmd_t cmd;
  fma_sts_t sts;

  assign cfg_i.ready = 1'b1;

  fma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fma_datapath #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_i      (in_i.sample),
    .last_i        (in_i.last),
    .cfg_we_i      (cfg_i.valid),
    .cfg_wdata_i   (cfg_i.window_len),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_average_o (out_o.average),
    .out_last_o    (out_o.last_out)
  );

  `FMA_CHECK(a_emit_ready, cmd.emit |-> (sts.div_done && sts.out_free), "emit without quotient")
  `FMA_CHECK(a_start_req, cmd.start |-> sts.emit_req, "divide started with no window due")
  `FMA_CHECK(a_emit_shows, cmd.emit |=> out_o.valid, "emitted average not presented")

endmodule
`default_nettype wire

[tb/sv/tb_forward_moving_average_core.sv]
`timescale 1ns / 100ps
module tb_forward_moving_average_core;

  localparam int unsigned RING_DEPTH    = 16;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned ITEM_TARGET   = 230;
  localparam int unsigned QUIET_FROM    = 190;

  typedef enum logic {ROW_ITEM, ROW_WINDOW} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [15:0] data;
    logic        lst;
    bit          typed;
    logic [15:0] t_avg;
    logic        t_fin;
  } row_t;

  typedef struct packed {
    logic signed [15:0] avg;
    logic               fin;
  } avg_t;

  localparam int unsigned NUM_ROWS = 28;

  row_t dir_rows [NUM_ROWS] = '{
    '{ROW_ITEM,   16'h7FFF, 1'b1, 1'b1, 16'h7FFF, 1'b1},
    '{ROW_ITEM,   16'h8000, 1'b1, 1'b1, 16'h8000, 1'b1},
    '{ROW_ITEM,   16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{ROW_ITEM,   16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h7FFF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'hFFFE, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h0003, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'hFFFC, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_WINDOW, 16'h0002, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h0005, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'hFFF9, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{ROW_WINDOW, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h0064, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'hFFFD, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{ROW_WINDOW, 16'h001F, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h4000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'hBFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{ROW_ITEM,   16'h0001, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{ROW_WINDOW, 16'h0010, 1'b0, 1'b0, 16'h0000, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  fma_in_if  #(.SAMPLE_WIDTH(16)) in_if ();
  fma_out_if #(.SAMPLE_WIDTH(16)) out_if ();
  fma_cfg_if                      cfg_if ();

  forward_moving_average_core #(
    .MAX_WINDOW  (16),
    .SAMPLE_WIDTH(16)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  logic signed [15:0] ring_q [RING_DEPTH];
  longint             run_sum;
  int unsigned        held;
  int unsigned        wr_slot;
  logic [4:0]         win_reg;

  avg_t        avg_new_q [$];
  avg_t        avg_expect_q [$];
  int unsigned errors;
  int unsigned items_sent;
  bit          quiet;
  bit          long_hold_req;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic void retire_oldest(input bit fin);
    longint q;
    q = run_sum / longint'(held);
    avg_new_q.push_back('{avg: q[15:0], fin: fin});
    run_sum -= ring_q[(wr_slot + RING_DEPTH - held) % RING_DEPTH];
    held--;
  endfunction

  function automatic void average_step(input logic signed [15:0] s, input logic lst);
    int unsigned w;
    w = (win_reg == 5'd0) ? 1 : ((win_reg > 5'd16) ? 16 : int'(win_reg));
    ring_q[wr_slot] = s;
    wr_slot = (wr_slot + 1) % RING_DEPTH;
    run_sum += s;
    held++;
    while (held >= w && held > 0) begin
      retire_oldest(lst && held == 1);
    end
    if (lst) begin
      while (held > 0) begin
        retire_oldest(held == 1);
      end
      run_sum = 0;
      wr_slot = 0;
    end
  endfunction

  function automatic logic [15:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_window();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd31;
      4: return 5'($urandom_range(17, 30));
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic wait_drained();
    while (avg_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_window(input logic [4:0] w);
    in_if.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.window_len <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    win_reg = w;
  endtask

  task automatic offer_sample(input logic [15:0] s, input logic lst, input bit typed,
                              input logic [15:0] t_avg, input logic t_fin);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.last   <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    average_step(s, lst);
    if (typed) begin
      avg_new_q.delete();
      avg_expect_q.push_back('{avg: t_avg, fin: t_fin});
    end else begin
      while (avg_new_q.size() > 0) avg_expect_q.push_back(avg_new_q.pop_front());
    end
    items_sent++;
  endtask

  initial begin
    avg_t        exp_avg;
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (avg_expect_q.size() == 0) begin
          $error("average: expected none, got %0d", $signed(out_if.average));
          errors++;
        end else begin
          exp_avg = avg_expect_q.pop_front();
          if (out_if.average !== exp_avg.avg) begin
            $error("average: expected %0d, got %0d", $signed(exp_avg.avg),
                   $signed(out_if.average));
            errors++;
          end
          if (out_if.last_out !== exp_avg.fin) begin
            $error("last_out: expected %0b, got %0b", exp_avg.fin, out_if.last_out);
            errors++;
          end
        end
      end
      if (stall_left == 0) begin
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          stall_left    = LONG_HOLD;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 9);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_forward_moving_average_core failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    errors        = 0;
    items_sent    = 0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    run_sum       = 0;
    held          = 0;
    wr_slot       = 0;
    win_reg       = 5'd5;
    foreach (ring_q[i]) ring_q[i] = '0;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.last        <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.window_len <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WINDOW) begin
        program_window(dir_rows[i].data[4:0]);
      end else begin
        offer_sample(dir_rows[i].data, dir_rows[i].lst, dir_rows[i].typed,
                     dir_rows[i].t_avg, dir_rows[i].t_fin);
      end
    end

    // The output is held off while a long stream keeps the input busy.
    program_window(5'd4);
    long_hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      offer_sample(pick_sample(), i == 29, 1'b0, '0, 1'b0);
    end
    in_if.valid <= 1'b0;
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) program_window(pick_window());
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        quiet = (items_sent >= QUIET_FROM);
        if (i > 0 && $urandom_range(0, 24) == 0) program_window(pick_window());
        offer_sample(pick_sample(), i == len - 1, 1'b0, '0, 1'b0);
      end
    end

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && avg_expect_q.size() == 0) begin
      $display("tb_forward_moving_average_core passed");
    end else begin
      $display("tb_forward_moving_average_core failed");
    end
    $finish;
  end

endmodule
